// File: rtl/core/rra_pkg.sv
`default_nettype none

package rra_pkg;

  localparam int unsigned SEQ_W          = 32;
  localparam int unsigned WINDOW_DEFAULT = 64;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } rra_state_t;

  // controller to datapath
  typedef struct packed {
    logic mark;      // input transfer, mark slot if in window
    logic release_;  // load head into output register and advance
  } rra_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit_head;  // incoming segment lands on the head slot
    logic rel_last;  // slot after the head is empty
  } rra_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rra_dp.sv
`default_nettype none

module rra_dp import rra_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SEQ_W-1:0] seq_num,
  input  wire rra_cmd_t         cmd,
  output rra_stat_t             stat,
  output logic      [SEQ_W-1:0] ack_seq,
  output logic                  last
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SEQ_W-1:0]  last_in_order;
  logic [WINDOW-1:0] filled;

  logic [SEQ_W-1:0]  slot_off;
  logic [SLOT_W-1:0] slot_idx;
  logic              in_window;
  logic [WINDOW-1:0] mark_vec;
  logic [WINDOW-1:0] filled_shift;

  // offset from the head; only meaningful when seq_num is above last_in_order
  assign slot_off  = seq_num - last_in_order - SEQ_W'(1);
  assign slot_idx  = slot_off[SLOT_W-1:0];
  assign in_window = (seq_num > last_in_order) && (slot_off < SEQ_W'(WINDOW));
  assign mark_vec  = WINDOW'(1) << slot_idx;

  assign filled_shift = filled >> 1;

  assign stat.hit_head = in_window && (slot_off == '0);
  assign stat.rel_last = ~filled_shift[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_in_order <= '0;
      filled        <= '0;
    end else if (cmd.release_) begin
      last_in_order <= last_in_order + SEQ_W'(1);
      filled        <= filled_shift;
    end else if (cmd.mark && in_window) begin
      filled <= filled | mark_vec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.release_) begin
      ack_seq <= last_in_order + SEQ_W'(1);
      last    <= ~filled_shift[0];
    end
  end

  a_gap_not_head: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark && !stat.hit_head && !filled[0]) |=> !filled[0])
    else $error("head slot marked without a head hit");

  a_release_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.release_ |=> (last_in_order == $past(last_in_order) + SEQ_W'(1)))
    else $error("release did not advance last_in_order");

  a_ack_matches: assert property (@(posedge clk) disable iff (rst)
    cmd.release_ |=> (ack_seq == last_in_order))
    else $error("acknowledged number differs from last_in_order");

endmodule

`default_nettype wire

// File: rtl/core/rra_ctrl.sv
`default_nettype none

module rra_ctrl import rra_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire rra_stat_t stat,
  output rra_cmd_t       cmd
);

  rra_state_t state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.mark       = 1'b0;
    cmd.release_   = 1'b0;
    out_valid_next = out_ready ? 1'b0 : out_valid;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.mark = in_valid;
        if (in_valid && stat.hit_head) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.release_   = 1'b1;
          out_valid_next = 1'b1;
          if (stat.rel_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.release_ |-> (!out_valid || out_ready))
    else $error("output register overwritten while stalled");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.release_ && stat.rel_last) |=> (state == ST_IDLE))
    else $error("final release did not return to idle");

  a_emit_after_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark && stat.hit_head) |=> (state == ST_EMIT))
    else $error("head hit did not start release");

endmodule

`default_nettype wire

// File: rtl/core/receive_reorder_ack_generator.sv
// receive reorder window with in-order acknowledgement release
//
// input channel: seq_num with in_valid / in_ready, one segment number per transfer
// output channel: ack_seq and last with out_valid / out_ready
//
// a segment above last_in_order and within WINDOW of it marks its slot in
// an occupancy bitmap; any other segment is dropped with no output. when the
// head slot fills, every consecutive filled slot is released, one
// acknowledgement per cycle while the output is free, with last set on
// the final one of the burst
// an in-window segment that releases nothing only marks its slot. a head
// hit moves the controller to ST_EMIT, where each release registers one
// ack together with out_valid, waiting while the output register is held.
// the release loop is one bitmap shift and one increment per cycle when free
//
// reset clears last_in_order and the bitmap at once, no clearing pass
// a stalled receiver holds the output register; release pauses until the
// pending ack transfers. input is taken only between release bursts
`default_nettype none

module receive_reorder_ack_generator import rra_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [SEQ_W-1:0] seq_num,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic      [SEQ_W-1:0] ack_seq,
  output logic                  last,
  output logic                  out_valid,
  input  wire logic             out_ready
);

  rra_cmd_t  cmd;
  rra_stat_t stat;

  // sequencing: accept, release burst, output valid
  rra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // window check, bitmap, head pointer and output register
  rra_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .seq_num (seq_num),
    .cmd     (cmd),
    .stat    (stat),
    .ack_seq (ack_seq),
    .last    (last)
  );

endmodule

`default_nettype wire
